// File: sv/tnsg_pkg.sv
// Shared types, constants and a helper function of the nine-sample touch filter.
package tnsg_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int RAW_BITS = 12;
  localparam int POS_BITS = 12;
  localparam int THRESH_BITS = 12;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;
  localparam int COUNT_BITS = 4;
  localparam int STAGES = 4;

  localparam logic [COUNT_BITS-1:0] LAST_COUNT = 4'd8;
  localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd1;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_ON_FAIL = 2'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_XFAIL    = 2'd1,
    ST_YFAIL    = 2'd2,
    ST_RELEASED = 2'd3
  } status_t;

  typedef struct packed {
    logic       acc;
    logic [1:0] grp;
    logic       capture;
    logic       clear;
    logic       en2;
    logic       en3;
    logic       en4;
  } lane_ctl_t;

  function automatic logic [1:0] group_of(input logic [COUNT_BITS-1:0] cnt);
    logic [1:0] g;
    case (cnt) inside
      [4'd0:4'd2]: g = 2'd0;
      [4'd3:4'd5]: g = 2'd1;
      default:     g = 2'd2;
    endcase
    return g;
  endfunction

endpackage

// File: sv/tnsg_sample_if.sv
// Input channel carrying one X/Y sample pair and the pen release flag.
interface tnsg_sample_if;
  logic                           valid;
  logic                           ready;
  logic [tnsg_pkg::RAW_BITS-1:0]  raw_x;
  logic [tnsg_pkg::RAW_BITS-1:0]  raw_y;
  logic                           pen_released;

  modport source (output valid, raw_x, raw_y, pen_released, input ready);
  modport sink (input valid, raw_x, raw_y, pen_released, output ready);
endinterface

// File: sv/tnsg_result_if.sv
// Output channel carrying one filtered position and its status.
interface tnsg_result_if;
  logic                           valid;
  logic                           ready;
  logic [tnsg_pkg::POS_BITS-1:0]  pos_x;
  logic [tnsg_pkg::POS_BITS-1:0]  pos_y;
  logic [1:0]                     status;

  modport source (output valid, pos_x, pos_y, status, input ready);
  modport sink (input valid, pos_x, pos_y, status, output ready);
endinterface

// File: sv/tnsg_cfg_if.sv
// Configuration write channel with register index and write data.
interface tnsg_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [tnsg_pkg::CFG_INDEX_BITS-1:0]  index;
  logic [tnsg_pkg::CFG_DATA_BITS-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/tnsg_axis_lane.sv
// One axis lane: group sum accumulation, divide by three, pairwise compare and pair average.
module tnsg_axis_lane #(
  parameter int SAMPLE_BITS = tnsg_pkg::SAMPLE_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  tnsg_pkg::lane_ctl_t                ctl,
  input  logic [SAMPLE_BITS-1:0]             sample,
  input  logic [tnsg_pkg::THRESH_BITS-1:0]   threshold,
  output logic                               fail,
  output logic [SAMPLE_BITS-1:0]             value
);

  localparam int SW = SAMPLE_BITS + 2;
  localparam int DIV3_SHIFT = SW + 2;
  localparam int MW = DIV3_SHIFT - 1;
  localparam int PW = SW + MW;
  localparam int CW = (SAMPLE_BITS > tnsg_pkg::THRESH_BITS) ? SAMPLE_BITS
                                                            : tnsg_pkg::THRESH_BITS;
  localparam logic [MW-1:0] DIV3_MUL = MW'(((1 << DIV3_SHIFT) + 2) / 3);

  logic [SW-1:0]          sums [3];
  logic [SW-1:0]          cap_next [3];
  logic [SW-1:0]          cap [3];
  logic [PW-1:0]          prod [3];
  logic [SAMPLE_BITS-1:0] avg [3];
  logic [SAMPLE_BITS-1:0] avg3 [3];
  logic [SAMPLE_BITS-1:0] diff_next [3];
  logic [SAMPLE_BITS-1:0] diff [3];
  logic [SAMPLE_BITS:0]   pair01;
  logic [SAMPLE_BITS:0]   pair12;
  logic [SAMPLE_BITS:0]   pair02;
  logic [SAMPLE_BITS:0]   pair_sel;
  logic [CW-1:0]          th;
  logic                   fail_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (ctl.grp == 2'(i)) begin
        cap_next[i] = sums[i] + SW'(sample);
      end else begin
        cap_next[i] = sums[i];
      end
      prod[i] = PW'(cap[i]) * PW'(DIV3_MUL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
    end else if (ctl.clear) begin
      for (int i = 0; i < 3; i++) begin
        sums[i] <= '0;
      end
    end else if (ctl.acc) begin
      for (int i = 0; i < 3; i++) begin
        sums[i] <= cap_next[i];
      end
    end
  end

  always_comb begin
    diff_next[0] = (avg[0] > avg[1]) ? avg[0] - avg[1] : avg[1] - avg[0];
    diff_next[1] = (avg[1] > avg[2]) ? avg[1] - avg[2] : avg[2] - avg[1];
    diff_next[2] = (avg[2] > avg[0]) ? avg[2] - avg[0] : avg[0] - avg[2];
  end

  always_comb begin
    th = CW'(threshold);
    fail_next = (CW'(diff[0]) > th) && (CW'(diff[1]) > th) && (CW'(diff[2]) > th);
    pair01 = (SAMPLE_BITS + 1)'(avg3[0]) + (SAMPLE_BITS + 1)'(avg3[1]);
    pair12 = (SAMPLE_BITS + 1)'(avg3[1]) + (SAMPLE_BITS + 1)'(avg3[2]);
    pair02 = (SAMPLE_BITS + 1)'(avg3[0]) + (SAMPLE_BITS + 1)'(avg3[2]);
    if (diff[0] < diff[1]) begin
      pair_sel = (diff[2] < diff[0]) ? pair02 : pair01;
    end else begin
      pair_sel = (diff[2] < diff[1]) ? pair02 : pair12;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (ctl.capture) begin
        cap[i] <= cap_next[i];
      end
      if (ctl.en2) begin
        avg[i] <= prod[i][DIV3_SHIFT +: SAMPLE_BITS];
      end
      if (ctl.en3) begin
        diff[i] <= diff_next[i];
        avg3[i] <= avg[i];
      end
    end
    if (ctl.en4) begin
      fail <= fail_next;
      value <= pair_sel[SAMPLE_BITS:1];
    end
  end

endmodule

// File: sv/tnsg_merge.sv
// Merge stage: combines both lane outcomes, keeps the held position and drives the result.
module tnsg_merge #(
  parameter int SAMPLE_BITS = tnsg_pkg::SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    valid,
  input  logic                    released,
  input  logic                    x_fail,
  input  logic [SAMPLE_BITS-1:0]  x_value,
  input  logic                    y_fail,
  input  logic [SAMPLE_BITS-1:0]  y_value,
  input  logic                    zero_on_fail,
  output logic                    ready,
  tnsg_result_if.source           result
);

  logic [tnsg_pkg::POS_BITS-1:0] held_x;
  logic [tnsg_pkg::POS_BITS-1:0] held_y;
  logic [tnsg_pkg::POS_BITS-1:0] held_x_next;
  logic [tnsg_pkg::POS_BITS-1:0] held_y_next;
  tnsg_pkg::status_t             status;
  tnsg_pkg::status_t             status_next;
  logic                          out_valid;
  logic                          take;

  assign ready = !out_valid || result.ready;
  assign take = valid && ready;

  always_comb begin
    held_x_next = held_x;
    held_y_next = held_y;
    if (released) begin
      status_next = tnsg_pkg::ST_RELEASED;
    end else if (x_fail) begin
      status_next = tnsg_pkg::ST_XFAIL;
    end else begin
      held_x_next = tnsg_pkg::POS_BITS'(x_value);
      if (y_fail) begin
        status_next = tnsg_pkg::ST_YFAIL;
      end else begin
        held_y_next = tnsg_pkg::POS_BITS'(y_value);
        status_next = tnsg_pkg::ST_OK;
      end
    end
    if (status_next != tnsg_pkg::ST_OK && zero_on_fail) begin
      held_x_next = '0;
      held_y_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_x <= '0;
      held_y <= '0;
      status <= tnsg_pkg::ST_OK;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        held_x <= held_x_next;
        held_y <= held_y_next;
        status <= status_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid = out_valid;
  assign result.pos_x = held_x;
  assign result.pos_y = held_y;
  assign result.status = status;

endmodule

// File: sv/touch_nine_sample_group_filter.sv
// Nine-sample touch filter: an X and a Y lane run side by side, a merge stage forms the result.
// A sample is taken every cycle. A set is closed by its ninth sample,
// or by a sample that carries the pen release flag before the set is full; the X and Y
// lanes take the set through four registered stages (capture, divide by three, differences,
// pair average) and the merge stage holds the result until it is taken. Input stalls only when
// all four stages hold sets while a result waits. Configuration writes are taken at once.
module touch_nine_sample_group_filter #(
  parameter int SAMPLE_BITS = tnsg_pkg::SAMPLE_BITS
) (
  input  logic            clk,
  input  logic            rst,
  tnsg_sample_if.sink     sample,
  tnsg_result_if.source   result,
  tnsg_cfg_if.sink        cfg
);

  localparam int ST = tnsg_pkg::STAGES;

  logic [tnsg_pkg::THRESH_BITS-1:0] threshold;
  logic                             zero_on_fail;
  logic [tnsg_pkg::COUNT_BITS-1:0]  count;
  logic                             last;
  logic                             accept;
  logic                             closes;
  logic [ST-1:0]                    stg_valid;
  logic [ST-1:0]                    stg_rel;
  logic [ST:0]                      rdy;
  logic [ST-1:0]                    load;
  logic                             merge_ready;
  tnsg_pkg::lane_ctl_t              ctl;
  logic [SAMPLE_BITS-1:0]           smp_x;
  logic [SAMPLE_BITS-1:0]           smp_y;
  logic                             x_fail;
  logic                             y_fail;
  logic [SAMPLE_BITS-1:0]           x_value;
  logic [SAMPLE_BITS-1:0]           y_value;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= tnsg_pkg::THRESH_RESET;
      zero_on_fail <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        tnsg_pkg::CFG_THRESHOLD:    threshold <= tnsg_pkg::THRESH_BITS'(cfg.data);
        tnsg_pkg::CFG_ZERO_ON_FAIL: zero_on_fail <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign last = count >= tnsg_pkg::LAST_COUNT;
  assign sample.ready = rdy[0];
  assign accept = sample.valid && sample.ready;
  assign closes = last || sample.pen_released;

  always_comb begin
    rdy[ST] = merge_ready;
    for (int k = ST - 1; k >= 0; k--) begin
      rdy[k] = !stg_valid[k] || rdy[k+1];
    end
    load[0] = accept && closes;
    for (int k = 1; k < ST; k++) begin
      load[k] = stg_valid[k-1] && rdy[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      stg_valid <= '0;
    end else begin
      if (accept) begin
        count <= closes ? '0 : count + 1'b1;
      end
      for (int k = 0; k < ST; k++) begin
        stg_valid[k] <= load[k] || (stg_valid[k] && !rdy[k+1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      stg_rel[0] <= !last;
    end
    for (int k = 1; k < ST; k++) begin
      if (load[k]) begin
        stg_rel[k] <= stg_rel[k-1];
      end
    end
  end

  always_comb begin
    ctl.acc = accept;
    ctl.grp = tnsg_pkg::group_of(count);
    ctl.capture = accept && last;
    ctl.clear = accept && closes;
    ctl.en2 = load[1];
    ctl.en3 = load[2];
    ctl.en4 = load[3];
  end

  assign smp_x = SAMPLE_BITS'(sample.raw_x);
  assign smp_y = SAMPLE_BITS'(sample.raw_y);

  tnsg_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sample    (smp_x),
    .threshold (threshold),
    .fail      (x_fail),
    .value     (x_value)
  );

  tnsg_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sample    (smp_y),
    .threshold (threshold),
    .fail      (y_fail),
    .value     (y_value)
  );

  tnsg_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
    .clk          (clk),
    .rst          (rst),
    .valid        (stg_valid[ST-1]),
    .released     (stg_rel[ST-1]),
    .x_fail       (x_fail),
    .x_value      (x_value),
    .y_fail       (y_fail),
    .y_value      (y_value),
    .zero_on_fail (zero_on_fail),
    .ready        (merge_ready),
    .result       (result)
  );

endmodule

// File: dv/testbench.sv
// Testbench of the nine-sample touch filter: a directed table, then random sets.
module testbench;

  typedef struct packed {
    logic [tnsg_pkg::POS_BITS-1:0] pos_x;
    logic [tnsg_pkg::POS_BITS-1:0] pos_y;
    tnsg_pkg::status_t             status;
  } position_t;

  typedef struct packed {
    logic [tnsg_pkg::RAW_BITS-1:0] raw_x;
    logic [tnsg_pkg::RAW_BITS-1:0] raw_y;
    logic                          pen_released;
    logic                          typed;
    position_t                     want;
  } row_t;

  localparam int SET_SIZE = 9;
  localparam int GROUP_SIZE = 3;
  localparam int FULL_SCALE = 4095;
  localparam int SETTLE_CYCLES = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SQUEEZE_CYCLES = 200;
  localparam int PHASES = 6;
  localparam int PRESSURE_PHASE = 2;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int RUSHED_ITEMS = 80;
  localparam int DIR_ROWS = 28;
  localparam position_t NONE = '{12'd0, 12'd0, tnsg_pkg::ST_OK};

  localparam row_t DIRECTED [DIR_ROWS] = '{
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b1, 1'b1, '{12'd4095, 12'd4095, tnsg_pkg::ST_OK}},
    '{12'd0,    12'd0,    1'b1, 1'b1, '{12'd4095, 12'd4095, tnsg_pkg::ST_RELEASED}},
    '{12'd0,    12'd4095, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd4095, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd4095, 1'b0, 1'b0, NONE},
    '{12'd2048, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd2048, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd2048, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b0, NONE},
    '{12'd4095, 12'd4095, 1'b0, 1'b1, '{12'd4095, 12'd4095, tnsg_pkg::ST_XFAIL}},
    '{12'd0,    12'd0,    1'b0, 1'b0, NONE},
    '{12'd0,    12'd0,    1'b0, 1'b0, NONE},
    '{12'd0,    12'd0,    1'b0, 1'b0, NONE},
    '{12'd0,    12'd2048, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd2048, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd2048, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd4095, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd4095, 1'b0, 1'b0, NONE},
    '{12'd0,    12'd4095, 1'b0, 1'b1, '{12'd0, 12'd4095, tnsg_pkg::ST_YFAIL}}
  };

  logic clk = 1'b0;
  logic rst;

  tnsg_sample_if smp_ch ();
  tnsg_result_if res_ch ();
  tnsg_cfg_if    cfg_ch ();

  touch_nine_sample_group_filter i_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [13:0]                      x_group_sum [GROUP_SIZE];
  logic [13:0]                      y_group_sum [GROUP_SIZE];
  logic [tnsg_pkg::COUNT_BITS-1:0]  taken;
  logic [tnsg_pkg::POS_BITS-1:0]    held_x;
  logic [tnsg_pkg::POS_BITS-1:0]    held_y;
  logic [tnsg_pkg::THRESH_BITS-1:0] thr_copy;
  logic                             zero_copy;

  position_t pending_positions [$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        rush = 1'b0;
  bit        calm = 1'b0;
  bit        squeeze_req = 1'b0;

  function automatic bit axis_fails(input logic [13:0] s0, s1, s2,
                                    input logic [tnsg_pkg::THRESH_BITS-1:0] thr,
                                    output logic [tnsg_pkg::POS_BITS-1:0] pick);
    logic [12:0] a0, a1, a2, d0, d1, d2;
    a0 = s0 / GROUP_SIZE;
    a1 = s1 / GROUP_SIZE;
    a2 = s2 / GROUP_SIZE;
    d0 = (a0 > a1) ? a0 - a1 : a1 - a0;
    d1 = (a1 > a2) ? a1 - a2 : a2 - a1;
    d2 = (a2 > a0) ? a2 - a0 : a0 - a2;
    pick = '0;
    if (d0 > thr && d1 > thr && d2 > thr) return 1'b1;
    if (d0 < d1) pick = (d2 < d0) ? 12'((a0 + a2) >> 1) : 12'((a0 + a1) >> 1);
    else         pick = (d2 < d1) ? 12'((a0 + a2) >> 1) : 12'((a1 + a2) >> 1);
    return 1'b0;
  endfunction

  task automatic clear_sets();
    for (int g = 0; g < GROUP_SIZE; g++) begin
      x_group_sum[g] = '0;
      y_group_sum[g] = '0;
    end
    taken = '0;
  endtask

  task automatic filter_step(input logic [tnsg_pkg::RAW_BITS-1:0] x, y, input logic rel,
                             output bit produced, output position_t p);
    logic [tnsg_pkg::COUNT_BITS-1:0] n;
    logic [1:0]                      g;
    logic [tnsg_pkg::POS_BITS-1:0]   v;
    tnsg_pkg::status_t               st;
    p = NONE;
    st = tnsg_pkg::ST_OK;
    produced = 1'b1;
    n = (taken <= tnsg_pkg::LAST_COUNT) ? taken : tnsg_pkg::LAST_COUNT;
    g = 2'(n / GROUP_SIZE);
    x_group_sum[g] += 14'(x);
    y_group_sum[g] += 14'(y);
    n++;
    if (n > tnsg_pkg::LAST_COUNT) begin
      if (axis_fails(x_group_sum[0], x_group_sum[1], x_group_sum[2], thr_copy, v)) begin
        st = tnsg_pkg::ST_XFAIL;
      end else begin
        held_x = v;
        if (axis_fails(y_group_sum[0], y_group_sum[1], y_group_sum[2], thr_copy, v)) begin
          st = tnsg_pkg::ST_YFAIL;
        end else begin
          held_y = v;
        end
      end
      clear_sets();
    end else if (rel) begin
      st = tnsg_pkg::ST_RELEASED;
      clear_sets();
    end else begin
      taken = n;
      produced = 1'b0;
    end
    if (produced) begin
      if (st != tnsg_pkg::ST_OK && zero_copy) begin
        held_x = '0;
        held_y = '0;
      end
      p = '{held_x, held_y, st};
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (rush || calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic feed(input logic [tnsg_pkg::RAW_BITS-1:0] x, y, input logic rel,
                      input logic typed, input position_t want);
    int        gap;
    bit        produced;
    position_t p;
    gap = pick_gap();
    if (gap > 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_ch.valid <= 1'b1;
    smp_ch.raw_x <= x;
    smp_ch.raw_y <= y;
    smp_ch.pen_released <= rel;
    do @(posedge clk); while (!smp_ch.ready);
    items_sent++;
    filter_step(x, y, rel, produced, p);
    if (typed) pending_positions.push_back(want);
    else if (produced) pending_positions.push_back(p);
  endtask

  task automatic settle();
    smp_ch.valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input logic [tnsg_pkg::THRESH_BITS-1:0] thr,
                            input logic zero_mode);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= tnsg_pkg::CFG_THRESHOLD;
    cfg_ch.data <= thr;
    do @(posedge clk); while (!cfg_ch.ready);
    thr_copy = thr;
    cfg_ch.index <= tnsg_pkg::CFG_ZERO_ON_FAIL;
    cfg_ch.data <= tnsg_pkg::CFG_DATA_BITS'(zero_mode);
    do @(posedge clk); while (!cfg_ch.ready);
    zero_copy = zero_mode;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [tnsg_pkg::RAW_BITS-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > FULL_SCALE) return tnsg_pkg::RAW_BITS'(FULL_SCALE);
    return tnsg_pkg::RAW_BITS'(v);
  endfunction

  // A set clusters around a base point per axis; groups are offset by about the threshold,
  // sometimes one group is pulled far away, and a few samples are plain noise.
  task automatic send_random_set(input bit rushed);
    int bx, by, spread, len, cut, k;
    int ox [GROUP_SIZE];
    int oy [GROUP_SIZE];
    logic [tnsg_pkg::RAW_BITS-1:0] x, y;
    logic rel;
    bx = $urandom_range(0, FULL_SCALE);
    by = $urandom_range(0, FULL_SCALE);
    case ($urandom_range(0, 4))
      0: spread = 0;
      1: spread = int'(thr_copy) / 2;
      2: spread = int'(thr_copy);
      3: spread = int'(thr_copy) + 2;
      default: spread = $urandom_range(0, FULL_SCALE);
    endcase
    for (int g = 0; g < GROUP_SIZE; g++) begin
      ox[g] = int'($urandom_range(0, 2 * spread)) - spread;
      oy[g] = int'($urandom_range(0, 2 * spread)) - spread;
    end
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, GROUP_SIZE - 1);
      ox[k] += $urandom_range(0, 1) ? int'($urandom_range(0, 2000))
                                    : -int'($urandom_range(0, 2000));
    end
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(0, GROUP_SIZE - 1);
      oy[k] += $urandom_range(0, 1) ? int'($urandom_range(0, 2000))
                                    : -int'($urandom_range(0, 2000));
    end
    if (rushed) cut = $urandom_range(1, 3);
    else cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, SET_SIZE - 1) : 0;
    len = (cut != 0) ? cut : SET_SIZE;
    calm = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        x = tnsg_pkg::RAW_BITS'($urandom_range(0, FULL_SCALE));
        y = tnsg_pkg::RAW_BITS'($urandom_range(0, FULL_SCALE));
      end else begin
        x = clamp_sample(bx + ox[i / GROUP_SIZE] + int'($urandom_range(0, 2)) - 1);
        y = clamp_sample(by + oy[i / GROUP_SIZE] + int'($urandom_range(0, 2)) - 1);
      end
      rel = (i == len - 1 && cut != 0) || (i == SET_SIZE - 1 && $urandom_range(0, 3) == 0)
            || ($urandom_range(0, 49) == 0);
      feed(x, y, rel, 1'b0, NONE);
    end
    calm = 1'b0;
  endtask

  initial begin
    logic [tnsg_pkg::THRESH_BITS-1:0] thr;
    int thr_plan [PHASES];
    bit zero_plan [PHASES];
    int start;
    thr_plan = '{0, 4095, 1, -1, -1, 4095};
    zero_plan = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
    rst <= 1'b1;
    smp_ch.valid <= 1'b0;
    smp_ch.raw_x <= '0;
    smp_ch.raw_y <= '0;
    smp_ch.pen_released <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= tnsg_pkg::CFG_THRESHOLD;
    cfg_ch.data <= '0;
    thr_copy = tnsg_pkg::THRESH_RESET;
    zero_copy = 1'b0;
    held_x = '0;
    held_y = '0;
    clear_sets();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      feed(DIRECTED[i].raw_x, DIRECTED[i].raw_y, DIRECTED[i].pen_released,
           DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (thr_plan[p] < 0) thr = tnsg_pkg::THRESH_BITS'($urandom_range(2, 300));
      else thr = tnsg_pkg::THRESH_BITS'(thr_plan[p]);
      write_regs(thr, zero_plan[p]);
      if (p == PRESSURE_PHASE) squeeze_req = 1'b1;
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        rush = (p == PRESSURE_PHASE) && (items_sent - start < RUSHED_ITEMS);
        send_random_set(rush);
      end
      rush = 1'b0;
    end

    settle();
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    int r;
    int span;
    logic level;
    res_ch.ready <= 1'b0;
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        level = 1'b0;
        span = SQUEEZE_CYCLES;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          level = 1'b1;
          span = $urandom_range(1, 20);
        end else if (r < 60) begin
          level = 1'b1;
          span = 100;
        end else if (r < 92) begin
          level = 1'b0;
          span = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          span = $urandom_range(10, 30);
        end
      end
      res_ch.ready <= level;
      repeat (span) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    position_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_positions.size() == 0) begin
        $error("unexpected position: pos_x %0d, pos_y %0d, status %0d",
               res_ch.pos_x, res_ch.pos_y, res_ch.status);
        mismatches++;
      end else begin
        want = pending_positions.pop_front();
        if (res_ch.pos_x !== want.pos_x) begin
          $error("pos_x: expected %0d, got %0d", want.pos_x, res_ch.pos_x);
          mismatches++;
        end
        if (res_ch.pos_y !== want.pos_y) begin
          $error("pos_y: expected %0d, got %0d", want.pos_y, res_ch.pos_y);
          mismatches++;
        end
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)
          || (cfg_ch.valid && cfg_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
sv/tnsg_pkg.sv
sv/tnsg_sample_if.sv
sv/tnsg_result_if.sv
sv/tnsg_cfg_if.sv
sv/tnsg_axis_lane.sv
sv/tnsg_merge.sv
sv/touch_nine_sample_group_filter.sv
dv/testbench.sv
